// ----- hw/rtl/i2cms_pkg.sv -----
// Shared types and constants for the two-wire bus master transfer sequencer.
package i2cms_pkg;

    // Width of the byte-count field on the request channel.
    localparam int XFER_LEN_W = 16;

    // Request codes carried in the action field.
    localparam logic [1:0] ACT_EVENT = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Bit positions of the controller status flags.
    localparam int FLG_START_SENT = 0;
    localparam int FLG_ADDR_DONE  = 1;
    localparam int FLG_BYTE_DONE  = 2;
    localparam int FLG_TX_EMPTY   = 3;
    localparam int FLG_RX_FULL    = 4;
    localparam int FLG_STOP_SEEN  = 5;

    // Bit positions of the reported event mask.
    localparam int EV_TX_DONE  = 0;
    localparam int EV_RX_DONE  = 1;
    localparam int EV_STOP     = 2;
    localparam int EV_DATA_REQ = 3;
    localparam int EV_DATA_RCV = 4;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_TX    = 2'd1,
        ST_RX    = 2'd2
    } t_xfer_state;

    typedef struct packed {
        logic [1:0]            action;
        logic [6:0]            slave_addr;
        logic [XFER_LEN_W-1:0] xfer_len;
        logic                  keep_bus;
        logic [5:0]            status_flags;
        logic                  master_mode;
        logic                  transmitter_mode;
        logic [7:0]            tx_byte;
        logic [7:0]            rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0] prior_state;
        logic       start_req;
        logic       byte_write_valid;
        logic [7:0] byte_write_value;
        logic       byte_read_valid;
        logic [7:0] byte_read_value;
        logic       stop_req;
        logic       ack_level;
        logic [4:0] event_mask;
        logic [1:0] irq_enables;
    } t_result;

endpackage

// ----- hw/rtl/i2cms_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration writes.
interface i2cms_item_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_item     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_result_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_result   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_cfg_if;
    logic valid;
    logic ready;
    logic ack_enable;
    modport source (output valid, output ack_enable, input ready);
    modport sink   (input valid, input ack_enable, output ready);
endinterface

// ----- hw/rtl/i2c_master_transfer_sequencer_unit.sv -----
// Top level of the two-wire bus master transfer sequencer.
//
// The block takes requests and controller status events on i_item and gives
// exactly one result per request on o_res. A start-write or start-read request
// is honored only while no transfer is running; it latches the address, the
// byte count and the keep-bus flag, raises start_req and enables interrupts.
// Status events then walk the transfer through address, data and stop.
// i_cfg writes the ack_enable register, which decides whether ACK is set again
// after a read completes; it is always ready and should only be written while
// the block is idle.
//
// Each transfer on i_item is captured in an input register, worked through by
// combinational logic and stored in the result register, which offers it on
// o_res. One request is taken every cycle as long as results are taken; the
// result register decides the rate.
// When o_res stalls, the result register holds its content, the input
// register fills once more, and then i_item.ready falls until o_res drains.
// Synchronous reset empties both registers, sets ack_enable to 1 and returns
// the sequencer to the ready state with interrupts and ACK off.
module i2c_master_transfer_sequencer_unit #(
    parameter int LEN_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cms_item_if.sink      i_item,
    i2cms_result_if.source  o_res,
    i2cms_cfg_if.sink       i_cfg
);
    import i2cms_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    r_ack_enable;
    logic    w_advance;
    t_result w_result;

    // The registered request moves on whenever the result register is free
    // or is being emptied in this cycle.
    assign w_advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
    end

    // The configuration register resets to acknowledge enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            r_ack_enable <= i_cfg.ack_enable;
        end
    end

    i2cms_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_item       (r_in),
        .i_ack_enable (r_ack_enable),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ----- hw/rtl/i2cms_core.sv -----
// Sequencer state registers and the single-pass next-state and result logic.
module i2cms_core #(
    parameter int LEN_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  i2cms_pkg::t_item   i_item,
    input  logic               i_ack_enable,
    output i2cms_pkg::t_result o_result
);
    import i2cms_pkg::*;

    t_xfer_state         r_state, n_state;
    logic [LEN_BITS-1:0] r_tx_left, n_tx_left;
    logic [LEN_BITS-1:0] r_rx_left, n_rx_left;
    logic [LEN_BITS-1:0] r_rx_total, n_rx_total;
    logic [6:0]          r_target_addr, n_target_addr;
    logic                r_hold_bus, n_hold_bus;
    logic                r_event_irq_on, n_event_irq_on;
    logic                r_buffer_irq_on, n_buffer_irq_on;
    logic                r_ack_bit, n_ack_bit;
    logic [LEN_BITS-1:0] w_len;

    // The byte count is kept in LEN_BITS bits.
    if (LEN_BITS <= XFER_LEN_W) begin : g_len_trunc
        assign w_len = i_item.xfer_len[LEN_BITS-1:0];
    end else begin : g_len_ext
        assign w_len = {{(LEN_BITS-XFER_LEN_W){1'b0}}, i_item.xfer_len};
    end

    always_comb begin
        logic busy;
        logic evon;
        logic bufon;
        logic [5:0] flags;
        n_state         = r_state;
        n_tx_left       = r_tx_left;
        n_rx_left       = r_rx_left;
        n_rx_total      = r_rx_total;
        n_target_addr   = r_target_addr;
        n_hold_bus      = r_hold_bus;
        n_event_irq_on  = r_event_irq_on;
        n_buffer_irq_on = r_buffer_irq_on;
        n_ack_bit       = r_ack_bit;
        o_result        = '0;
        o_result.prior_state = r_state;
        busy  = (r_state == ST_TX) || (r_state == ST_RX);
        evon  = r_event_irq_on;
        bufon = r_buffer_irq_on;
        flags = i_item.status_flags;

        if ((i_item.action == ACT_WRITE || i_item.action == ACT_READ) && !busy) begin
            n_target_addr = i_item.slave_addr;
            n_hold_bus    = i_item.keep_bus;
            if (i_item.action == ACT_WRITE) begin
                n_tx_left = w_len;
                n_state   = ST_TX;
            end else begin
                n_rx_left  = w_len;
                n_rx_total = w_len;
                n_state    = ST_RX;
            end
            o_result.start_req = 1'b1;
            n_event_irq_on     = 1'b1;
            n_buffer_irq_on    = 1'b1;
        end else if (i_item.action == ACT_EVENT) begin
            // Start sent: address byte with the direction bit.
            if (evon && flags[FLG_START_SENT]) begin
                if (r_state == ST_TX) begin
                    o_result.byte_write_valid = 1'b1;
                    o_result.byte_write_value = {r_target_addr, 1'b0};
                end else if (r_state == ST_RX) begin
                    o_result.byte_write_valid = 1'b1;
                    o_result.byte_write_value = {r_target_addr, 1'b1};
                end
            end
            // Address done on a single-byte read: drop ACK early.
            if (evon && flags[FLG_ADDR_DONE] && i_item.master_mode &&
                r_state == ST_RX && r_rx_total == LEN_BITS'(1)) begin
                n_ack_bit = 1'b0;
            end
            // Byte finished with nothing left to send closes the write.
            if (evon && flags[FLG_BYTE_DONE] && r_state == ST_TX &&
                flags[FLG_TX_EMPTY] && r_tx_left == '0) begin
                o_result.stop_req                = !r_hold_bus;
                n_event_irq_on                   = 1'b0;
                n_buffer_irq_on                  = 1'b0;
                n_state                          = ST_READY;
                n_tx_left                        = '0;
                o_result.event_mask[EV_TX_DONE]  = 1'b1;
            end
            if (evon && flags[FLG_STOP_SEEN]) begin
                o_result.event_mask[EV_STOP] = 1'b1;
            end
            // A write that closed above had no bytes left, so the original
            // state and count decide here.
            if (evon && bufon && flags[FLG_TX_EMPTY]) begin
                if (i_item.master_mode) begin
                    if (r_state == ST_TX && r_tx_left != '0) begin
                        o_result.byte_write_valid = 1'b1;
                        o_result.byte_write_value = i_item.tx_byte;
                        n_tx_left                 = r_tx_left - LEN_BITS'(1);
                    end
                end else if (i_item.transmitter_mode) begin
                    o_result.event_mask[EV_DATA_REQ] = 1'b1;
                end
            end
            if (evon && bufon && flags[FLG_RX_FULL]) begin
                if (i_item.master_mode) begin
                    if (r_state == ST_RX) begin
                        if (r_rx_total == LEN_BITS'(1)) begin
                            o_result.byte_read_valid = 1'b1;
                            o_result.byte_read_value = i_item.rx_byte;
                            n_rx_left                = r_rx_left - LEN_BITS'(1);
                        end else if (r_rx_total > LEN_BITS'(1)) begin
                            if ({1'b0, r_rx_left} == (LEN_BITS+1)'(2)) begin
                                n_ack_bit = 1'b0;
                            end
                            o_result.byte_read_valid = 1'b1;
                            o_result.byte_read_value = i_item.rx_byte;
                            n_rx_left                = r_rx_left - LEN_BITS'(1);
                        end
                        if (n_rx_left == '0) begin
                            o_result.stop_req               = !r_hold_bus;
                            n_event_irq_on                  = 1'b0;
                            n_buffer_irq_on                 = 1'b0;
                            n_state                         = ST_READY;
                            n_rx_total                      = '0;
                            if (i_ack_enable) begin
                                n_ack_bit = 1'b1;
                            end
                            o_result.event_mask[EV_RX_DONE] = 1'b1;
                        end
                    end
                end else if (!i_item.transmitter_mode) begin
                    o_result.event_mask[EV_DATA_RCV] = 1'b1;
                end
            end
        end

        o_result.ack_level   = n_ack_bit;
        o_result.irq_enables = {n_buffer_irq_on, n_event_irq_on};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_READY;
            r_tx_left       <= '0;
            r_rx_left       <= '0;
            r_rx_total      <= '0;
            r_target_addr   <= '0;
            r_hold_bus      <= 1'b0;
            r_event_irq_on  <= 1'b0;
            r_buffer_irq_on <= 1'b0;
            r_ack_bit       <= 1'b0;
        end else if (i_advance) begin
            r_state         <= n_state;
            r_tx_left       <= n_tx_left;
            r_rx_left       <= n_rx_left;
            r_rx_total      <= n_rx_total;
            r_target_addr   <= n_target_addr;
            r_hold_bus      <= n_hold_bus;
            r_event_irq_on  <= n_event_irq_on;
            r_buffer_irq_on <= n_buffer_irq_on;
            r_ack_bit       <= n_ack_bit;
        end
    end

endmodule

// ----- hw/rtl/i2cms_checker.sv -----
// Port-level checks on the result channel of the transfer sequencer.
module i2cms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input i2cms_pkg::t_result i_res
);
    import i2cms_pkg::*;

    // A held result keeps its content until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("result changed while stalled");

    // A start is only granted from the ready state and enables both interrupts.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.start_req |->
            i_res.prior_state == ST_READY && i_res.irq_enables == 2'b11 &&
            !i_res.byte_write_valid && !i_res.byte_read_valid && !i_res.stop_req)
        else $error("start granted from a busy state");

    // A completed transfer leaves both interrupt enables off.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res.event_mask[EV_TX_DONE] || i_res.event_mask[EV_RX_DONE]) |->
            i_res.irq_enables == 2'b00 && !i_res.start_req)
        else $error("completion left interrupts enabled");

    // Byte values are zero unless their valid flag is set.
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            (i_res.byte_write_valid || i_res.byte_write_value == 8'd0) &&
            (i_res.byte_read_valid || i_res.byte_read_value == 8'd0))
        else $error("byte value without valid flag");

endmodule

bind i2c_master_transfer_sequencer_unit i2cms_checker u_i2cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.data)
);

// ----- verif/i2cms_transfer_checker.sv -----
// Checker that predicts every result of the transfer sequencer and compares it.
module i2cms_transfer_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    i2cms_item_if   item_ch,
    i2cms_result_if res_ch,
    i2cms_cfg_if    cfg_ch,
    output int      o_outstanding,
    output int      o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    // Private copy of the sequencer state and of the ack_enable register.
    t_xfer_state           seq_state;
    logic [XFER_LEN_W-1:0] bytes_to_send;
    logic [XFER_LEN_W-1:0] bytes_to_read;
    logic [XFER_LEN_W-1:0] read_length;
    logic [6:0]            latched_addr;
    logic                  hold_bus_q;
    logic                  evt_irq_en;
    logic                  buf_irq_en;
    logic                  ack_q;
    logic                  ack_restore;

    t_result expected_q[$];
    int      mismatches = 0;

    // Works one request or status event through the sequencer and returns the result.
    function automatic t_result predict_result(input t_item it);
        t_result r;
        logic    evt_on;
        logic    buf_on;
        logic    busy;
        r = '0;
        r.prior_state = seq_state;
        busy = (seq_state == ST_TX) || (seq_state == ST_RX);
        if ((it.action == ACT_WRITE || it.action == ACT_READ) && !busy) begin
            latched_addr = it.slave_addr;
            hold_bus_q = it.keep_bus;
            if (it.action == ACT_WRITE) begin
                bytes_to_send = it.xfer_len;
                seq_state = ST_TX;
            end else begin
                bytes_to_read = it.xfer_len;
                read_length = it.xfer_len;
                seq_state = ST_RX;
            end
            r.start_req = 1'b1;
            evt_irq_en = 1'b1;
            buf_irq_en = 1'b1;
        end else if (it.action == ACT_EVENT) begin
            // The enables are sampled once, so a completion leaves later checks live.
            evt_on = evt_irq_en;
            buf_on = buf_irq_en;
            if (evt_on && it.status_flags[FLG_START_SENT]) begin
                if (seq_state == ST_TX) begin
                    r.byte_write_valid = 1'b1;
                    r.byte_write_value = {latched_addr, 1'b0};
                end else if (seq_state == ST_RX) begin
                    r.byte_write_valid = 1'b1;
                    r.byte_write_value = {latched_addr, 1'b1};
                end
            end
            if (evt_on && it.status_flags[FLG_ADDR_DONE]) begin
                if (it.master_mode && seq_state == ST_RX && read_length == 1)
                    ack_q = 1'b0;
            end
            if (evt_on && it.status_flags[FLG_BYTE_DONE]) begin
                if (seq_state == ST_TX && it.status_flags[FLG_TX_EMPTY] && bytes_to_send == 0) begin
                    r.stop_req = !hold_bus_q;
                    evt_irq_en = 1'b0;
                    buf_irq_en = 1'b0;
                    seq_state = ST_READY;
                    bytes_to_send = '0;
                    r.event_mask[EV_TX_DONE] = 1'b1;
                end
            end
            if (evt_on && it.status_flags[FLG_STOP_SEEN])
                r.event_mask[EV_STOP] = 1'b1;
            if (evt_on && buf_on && it.status_flags[FLG_TX_EMPTY]) begin
                if (it.master_mode) begin
                    if (seq_state == ST_TX && bytes_to_send != 0) begin
                        r.byte_write_valid = 1'b1;
                        r.byte_write_value = it.tx_byte;
                        bytes_to_send = bytes_to_send - 1'b1;
                    end
                end else if (it.transmitter_mode) begin
                    r.event_mask[EV_DATA_REQ] = 1'b1;
                end
            end
            if (evt_on && buf_on && it.status_flags[FLG_RX_FULL]) begin
                if (it.master_mode) begin
                    if (seq_state == ST_RX) begin
                        if (read_length == 1) begin
                            r.byte_read_valid = 1'b1;
                            r.byte_read_value = it.rx_byte;
                            bytes_to_read = bytes_to_read - 1'b1;
                        end else if (read_length > 1) begin
                            // NACK goes out with the last byte, so ACK drops one byte early.
                            if (bytes_to_read == 2)
                                ack_q = 1'b0;
                            r.byte_read_valid = 1'b1;
                            r.byte_read_value = it.rx_byte;
                            bytes_to_read = bytes_to_read - 1'b1;
                        end
                        // A zero-length read ends here without delivering a byte.
                        if (bytes_to_read == 0) begin
                            r.stop_req = !hold_bus_q;
                            evt_irq_en = 1'b0;
                            buf_irq_en = 1'b0;
                            seq_state = ST_READY;
                            bytes_to_read = '0;
                            read_length = '0;
                            if (ack_restore)
                                ack_q = 1'b1;
                            r.event_mask[EV_RX_DONE] = 1'b1;
                        end
                    end
                end else if (!it.transmitter_mode) begin
                    r.event_mask[EV_DATA_RCV] = 1'b1;
                end
            end
        end
        r.ack_level = ack_q;
        r.irq_enables = {buf_irq_en, evt_irq_en};
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            seq_state = ST_READY;
            bytes_to_send = '0;
            bytes_to_read = '0;
            read_length = '0;
            latched_addr = '0;
            hold_bus_q = 1'b0;
            evt_irq_en = 1'b0;
            buf_irq_en = 1'b0;
            ack_q = 1'b0;
            ack_restore = 1'b1;
            expected_q.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                             $time, got);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("prior_state", want.prior_state, got.prior_state);
                    compare_field("start_req", want.start_req, got.start_req);
                    compare_field("byte_write_valid", want.byte_write_valid,
                                  got.byte_write_valid);
                    compare_field("byte_write_value", want.byte_write_value,
                                  got.byte_write_value);
                    compare_field("byte_read_valid", want.byte_read_valid,
                                  got.byte_read_valid);
                    compare_field("byte_read_value", want.byte_read_value,
                                  got.byte_read_value);
                    compare_field("stop_req", want.stop_req, got.stop_req);
                    compare_field("ack_level", want.ack_level, got.ack_level);
                    compare_field("event_mask", want.event_mask, got.event_mask);
                    compare_field("irq_enables", want.irq_enables, got.irq_enables);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                ack_restore = cfg_ch.ack_enable;
            if (item_ch.valid && item_ch.ready)
                expected_q.push_back(predict_result(item_ch.data));
        end
        o_outstanding = expected_q.size();
        o_mismatches = mismatches;
    end

endmodule

// ----- verif/i2c_master_transfer_sequencer_unit_tb.sv -----
// Testbench top for the transfer sequencer: stimulus, idling phases and verdict.
module i2c_master_transfer_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    // The action field has one code that the block does not define; it must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Single-flag masks for building status events.
    localparam logic [5:0] F_START    = 6'b1 << FLG_START_SENT;
    localparam logic [5:0] F_ADDR     = 6'b1 << FLG_ADDR_DONE;
    localparam logic [5:0] F_BYTE     = 6'b1 << FLG_BYTE_DONE;
    localparam logic [5:0] F_TX_EMPTY = 6'b1 << FLG_TX_EMPTY;
    localparam logic [5:0] F_RX_FULL  = 6'b1 << FLG_RX_FULL;
    localparam logic [5:0] F_STOP     = 6'b1 << FLG_STOP_SEEN;

    // At least 385 sequence items in each of five phases, after the directed part.
    localparam int PHASE_ITEMS = 385;

    // The slowest legal run is far below this: about 2000 transfers on the request
    // channel, even with one side idling heavily.
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;

    i2cms_item_if   item_ch();
    i2cms_result_if res_ch();
    i2cms_cfg_if    cfg_ch();

    int outstanding;
    int mismatches;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;
    int live_items = 0;
    int writes_done = 0;
    int reads_done = 0;

    i2c_master_transfer_sequencer_unit #(
        .LEN_BITS(XFER_LEN_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    i2cms_transfer_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .item_ch       (item_ch),
        .res_ch        (res_ch),
        .cfg_ch        (cfg_ch),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    initial i_clk = 1'b0;
    always #5ns i_clk = ~i_clk;

    // Watchdog: a hung handshake or a missing result ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still expected.",
                     cycle_count, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The result side stalls on its own, once per cycle, at the phase's rate.
    // One nonblocking write per falling edge, so ready never glitches within a step.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every field random; callers then pin down what the case needs.
    function automatic t_item random_fields();
        t_item it;
        it.action = 2'($urandom_range(3));
        it.slave_addr = 7'($urandom_range(127));
        it.xfer_len = XFER_LEN_W'($urandom);
        it.keep_bus = 1'($urandom_range(1));
        it.status_flags = 6'($urandom_range(63));
        it.master_mode = 1'($urandom_range(1));
        it.transmitter_mode = 1'($urandom_range(1));
        it.tx_byte = 8'($urandom_range(255));
        it.rx_byte = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic t_item make_start(input logic [1:0] action, input logic [6:0] addr,
                                         input int len, input logic keep);
        t_item it;
        it = random_fields();
        it.action = action;
        it.slave_addr = addr;
        it.xfer_len = XFER_LEN_W'(len);
        it.keep_bus = keep;
        return it;
    endfunction

    function automatic t_item make_event(input logic [5:0] flags, input logic master,
                                         input logic transmitter);
        t_item it;
        it = random_fields();
        it.action = ACT_EVENT;
        it.status_flags = flags;
        it.master_mode = master;
        it.transmitter_mode = transmitter;
        return it;
    endfunction

    // Mostly short transfers, now and then a longer one.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 4);
        else if (r < 95)
            return $urandom_range(5, 16);
        return $urandom_range(17, 48);
    endfunction

    // Called at a falling edge. Holds the request until the block takes the transfer,
    // then, at the next falling edge, may drop valid for a random stretch of cycles.
    // When no gap is taken, valid simply stays high for the caller's next request.
    task automatic send_request(input t_item it, input bit counted);
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        if (counted)
            live_items++;
        @(negedge i_clk);
        if ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < src_idle_pct)
                @(negedge i_clk);
        end
    endtask

    task automatic send_event(input logic [5:0] flags, input logic master,
                              input logic transmitter);
        send_request(make_event(flags, master, transmitter), 1'b1);
    endtask

    // Noise that leaves a running transfer untouched: start requests that must be
    // refused, the undefined action, and status events seen while not bus master.
    // Byte-finished is kept out so a write with nothing left cannot end early.
    task automatic send_busy_noise();
        t_item it;
        it = random_fields();
        case ($urandom_range(2))
            0: begin
                it.action = $urandom_range(1) ? ACT_WRITE : ACT_READ;
            end
            1: begin
                it.action = ACT_UNUSED;
            end
            default: begin
                it.action = ACT_EVENT;
                it.master_mode = 1'b0;
                it.status_flags = it.status_flags & ~F_BYTE;
            end
        endcase
        send_request(it, 1'b1);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(9) == 0)
            send_busy_noise();
    endtask

    // A write transfer: start, address phase, one tx-empty event per data byte, and
    // the closing byte-finished plus tx-empty. Extra flags ride along at random; none
    // of them can disturb the byte count while bytes remain. Now and then the address
    // phase is skipped, which the sequencer must tolerate.
    task automatic write_transfer(input logic [6:0] addr, input int len, input logic keep);
        int         left;
        logic [5:0] flags;
        send_request(make_start(ACT_WRITE, addr, len, keep), 1'b1);
        left = len;
        if ($urandom_range(4) != 0) begin
            flags = F_START | ($urandom_range(1) ? F_ADDR : 6'b0);
            // Address byte and first data byte written by the same event.
            if (left > 0 && $urandom_range(2) == 0) begin
                flags = flags | F_TX_EMPTY;
                left--;
            end
            send_event(flags, 1'b1, 1'($urandom_range(1)));
        end
        while (left > 0) begin
            maybe_noise();
            send_event(6'($urandom_range(63)) | F_TX_EMPTY, 1'b1, 1'($urandom_range(1)));
            left--;
        end
        maybe_noise();
        // Completion does not look at the master flag, so the later checks of this
        // event see the ready state with the enables still sampled on.
        send_event(6'($urandom_range(63)) | F_BYTE | F_TX_EMPTY, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        writes_done++;
    endtask

    // A read transfer: start, address phase, then rx-full events until the count is
    // used up. A zero-length read takes a single rx-full event to finish.
    task automatic read_transfer(input logic [6:0] addr, input int len, input logic keep);
        int left;
        send_request(make_start(ACT_READ, addr, len, keep), 1'b1);
        if ($urandom_range(4) != 0)
            send_event(F_START | ($urandom_range(1) ? F_ADDR : 6'b0), 1'b1,
                       1'($urandom_range(1)));
        send_event(F_ADDR | ($urandom_range(1) ? F_STOP : 6'b0), 1'($urandom_range(3) != 0),
                   1'($urandom_range(1)));
        left = (len == 0) ? 1 : len;
        while (left > 0) begin
            maybe_noise();
            send_event(6'($urandom_range(63)) | F_RX_FULL, 1'b1, 1'($urandom_range(1)));
            left--;
        end
        reads_done++;
    endtask

    // While the sequencer is ready its interrupts are off, so events and the
    // undefined action must pass through with nothing but the levels reported.
    task automatic send_idle_noise();
        t_item it;
        it = random_fields();
        it.action = $urandom_range(1) ? ACT_EVENT : ACT_UNUSED;
        send_request(it, 1'b1);
    endtask

    task automatic run_random(input int target);
        int first;
        int pick;
        first = live_items;
        while (live_items - first < target) begin
            pick = $urandom_range(99);
            if (pick < 44)
                write_transfer(7'($urandom_range(127)), pick_length(), 1'($urandom_range(1)));
            else if (pick < 88)
                read_transfer(7'($urandom_range(127)), pick_length(), 1'($urandom_range(1)));
            else
                repeat ($urandom_range(1, 3)) send_idle_noise();
        end
    endtask

    // Called at a falling edge: stop requesting and wait for every result to be back.
    // Each request yields exactly one result, so an empty queue means an idle block.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    task automatic write_ack_enable(input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.ack_enable <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_directed();
        t_item it;
        // All flags at once while ready, with every other field at its top value.
        it = make_event('1, 1'b1, 1'b1);
        it.slave_addr = '1;
        it.xfer_len = '1;
        it.keep_bus = 1'b1;
        it.tx_byte = '1;
        it.rx_byte = '1;
        send_request(it, 1'b1);
        // The undefined action with every bit set.
        it = '1;
        it.action = ACT_UNUSED;
        send_request(it, 1'b1);
        // One-byte write to the highest address; a start while busy is refused.
        send_request(make_start(ACT_WRITE, 7'h7F, 1, 1'b0), 1'b1);
        send_request(make_start(ACT_READ, 7'h00, 16'hFFFF, 1'b1), 1'b1);
        // Address byte and the data byte in one event: the data byte is reported.
        it = make_event(F_START | F_ADDR | F_TX_EMPTY, 1'b1, 1'b1);
        it.tx_byte = '1;
        send_request(it, 1'b1);
        // Completion followed by stop-seen and a data request in the same event.
        send_event(F_BYTE | F_TX_EMPTY | F_STOP | F_RX_FULL, 1'b0, 1'b1);
        // Zero-length read with the bus held: no byte, no stop.
        send_request(make_start(ACT_READ, 7'h00, 0, 1'b1), 1'b1);
        send_event(F_START, 1'b1, 1'b0);
        it = make_event(F_RX_FULL, 1'b1, 1'b0);
        it.rx_byte = '0;
        send_request(it, 1'b1);
        // One-byte read: ACK drops at address done, then byte, stop and completion.
        send_request(make_start(ACT_READ, 7'h55, 1, 1'b0), 1'b1);
        send_event(F_START | F_ADDR, 1'b1, 1'b0);
        send_event(F_RX_FULL | F_STOP, 1'b1, 1'b0);
        // Three-byte read with slave-role events and a refused start in the middle.
        send_request(make_start(ACT_READ, 7'h2A, 3, 1'b0), 1'b1);
        send_event(F_START, 1'b1, 1'b0);
        send_event(F_ADDR, 1'b1, 1'b0);
        send_event(F_RX_FULL, 1'b0, 1'b0);
        send_event(F_TX_EMPTY, 1'b0, 1'b1);
        send_request(make_start(ACT_WRITE, 7'h11, 5, 1'b0), 1'b1);
        send_event(F_RX_FULL, 1'b1, 1'b0);
        send_event(F_RX_FULL, 1'b1, 1'b0);
        send_event(F_RX_FULL, 1'b1, 1'b0);
        // Empty write with the bus held, then data received after completion.
        send_request(make_start(ACT_WRITE, 7'h00, 0, 1'b1), 1'b1);
        send_event(F_START, 1'b1, 1'b1);
        send_event(F_BYTE | F_TX_EMPTY | F_RX_FULL, 1'b0, 1'b0);
        reads_done += 3;
        writes_done += 2;
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.ack_enable = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: no idling; ACK restore off for the directed cases.
        write_ack_enable(1'b0);
        run_directed();
        run_random(PHASE_ITEMS);
        drain();

        // Phase two: the request side is idle most of the time.
        write_ack_enable(1'b1);
        src_idle_pct = 77;
        run_random(PHASE_ITEMS);
        drain();

        // Phase three: the result side stalls most of the time.
        write_ack_enable(1'b0);
        src_idle_pct = 0;
        sink_stall_pct = 77;
        run_random(PHASE_ITEMS);
        drain();

        // Phase four: both sides idle now and then.
        write_ack_enable(1'b1);
        src_idle_pct = 28;
        sink_stall_pct = 28;
        run_random(PHASE_ITEMS);
        drain();

        // Phase five: back to full rate with ACK restore on.
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain();

        // Wait on after the drain so nothing stray slips by.
        repeat (8) @(negedge i_clk);

        $display("Covered %0d sequence transfers in five idling phases: %0d writes, %0d reads.",
                 live_items, writes_done, reads_done);
        $display("ACK restore was switched off and on between phases; %0d mismatches seen.",
                 mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
